### hw/rtl/rmt_pkg.sv
// Shared types and constants for the recursive mutex table.
// Holds the request, result and slot entry types and the state enum.
// No dependencies.
`default_nettype none

package rmt_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int NUM_THREADS = 16;
  localparam int MAX_COUNT   = 255;

  localparam int SLOT_W   = $clog2(NUM_SLOTS);
  localparam int THREAD_W = $clog2(NUM_THREADS);
  localparam int COUNT_W  = $clog2(MAX_COUNT + 1);

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_ACQUIRE  = 3'd1;
  localparam logic [2:0] OP_RELEASE  = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_FREE_ALL = 3'd4;
  localparam logic [2:0] OP_QUERY    = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_LOCK   = 3'd1;
  localparam logic [2:0] STS_EXISTS    = 3'd2;
  localparam logic [2:0] STS_BUSY      = 3'd3;
  localparam logic [2:0] STS_BAD_INDEX = 3'd4;
  localparam logic [2:0] STS_OVERFLOW  = 3'd5;

  typedef struct packed {
    logic [2:0]          operation;
    logic [SLOT_W-1:0]   mutex_index;
    logic [THREAD_W-1:0] thread_id;
    logic                recursive_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                is_present;
    logic                is_held;
    logic [THREAD_W-1:0] owner_thread;
    logic [COUNT_W-1:0]  hold_count;
  } res_t;

  typedef struct packed {
    logic                recursive;
    logic                held;
    logic [THREAD_W-1:0] owner;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/rmt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module rmt_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/recursive_mutex_table_unit.sv
// Top level of the recursive mutex table: control FSM, present bits, result register.
// Depends on rmt_pkg and rmt_ram (slot entry storage).
//
//   channel   ports                      direction  accepted when
//   request   start, request, busy       in         start & !busy at clk edge
//   result    done, result               out        every cycle done is high
//
// Single-slot requests: IDLE issues the RAM read, EXEC modifies the entry and writes it
// back if changed; the result shows in the next cycle, while the next request can start.
// Free-all walks every slot, one per cycle.
// Reset clears the present bits and the FSM; the entry RAM is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per request.
`default_nettype none

module recursive_mutex_table_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rmt_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output rmt_pkg::res_t      result
);

  rmt_pkg::state_t state, state_next;
  rmt_pkg::req_t   req_q;
  logic [rmt_pkg::NUM_SLOTS-1:0] present;
  logic [rmt_pkg::SLOT_W-1:0]    walk_idx;
  logic                          walk_last;

  logic                          wr_en;
  logic [rmt_pkg::SLOT_W-1:0]    wr_addr;
  rmt_pkg::entry_t               wr_data;
  logic [rmt_pkg::SLOT_W-1:0]    rd_addr;
  rmt_pkg::entry_t               rd_entry;

  logic          set_pres;
  logic          clr_pres;
  logic          done_next;
  rmt_pkg::res_t res_next;
  logic          accept;
  logic          pres;
  rmt_pkg::entry_t upd;
  logic [rmt_pkg::COUNT_W-1:0] dec_count;

  function automatic rmt_pkg::res_t make_res(logic [2:0] sts, logic p, rmt_pkg::entry_t e);
    rmt_pkg::res_t r;
    r.status       = sts;
    r.is_present   = p;
    r.is_held      = p & e.held;
    r.owner_thread = (p && e.held) ? e.owner : '0;
    r.hold_count   = p ? e.count : '0;
    return r;
  endfunction

  assign busy      = (state != rmt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign walk_last = (walk_idx == rmt_pkg::SLOT_W'(rmt_pkg::NUM_SLOTS - 1));
  assign pres      = present[req_q.mutex_index];

  rmt_ram #(
    .WIDTH ($bits(rmt_pkg::entry_t)),
    .DEPTH (rmt_pkg::NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      rmt_pkg::S_IDLE: begin
        if (start) begin
          state_next = (request.operation == rmt_pkg::OP_FREE_ALL) ?
                       rmt_pkg::S_WALK : rmt_pkg::S_EXEC;
        end
      end
      rmt_pkg::S_EXEC: state_next = rmt_pkg::S_IDLE;
      rmt_pkg::S_WALK: begin
        if (walk_last) begin
          state_next = rmt_pkg::S_IDLE;
        end
      end
      default: state_next = rmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = req_q.mutex_index;
    wr_data   = rd_entry;
    set_pres  = 1'b0;
    clr_pres  = 1'b0;
    done_next = 1'b0;
    res_next  = make_res(rmt_pkg::STS_OK, 1'b0, rd_entry);
    rd_addr   = req_q.mutex_index;
    upd       = rd_entry;
    dec_count = (rd_entry.count != '0) ? rd_entry.count - 1'b1 : rd_entry.count;
    case (state)
      rmt_pkg::S_IDLE: begin
        rd_addr = (request.operation == rmt_pkg::OP_FREE_ALL) ? '0 : request.mutex_index;
      end
      rmt_pkg::S_EXEC: begin
        done_next = 1'b1;
        if (req_q.mutex_index == '0) begin
          res_next = make_res(rmt_pkg::STS_BAD_INDEX, 1'b0, rd_entry);
        end else if (req_q.operation == rmt_pkg::OP_CREATE) begin
          if (pres) begin
            res_next = make_res(rmt_pkg::STS_EXISTS, 1'b1, rd_entry);
          end else begin
            upd.recursive = req_q.recursive_flag;
            upd.held      = 1'b0;
            upd.owner     = '0;
            upd.count     = '0;
            wr_en         = 1'b1;
            wr_data       = upd;
            set_pres      = 1'b1;
            res_next      = make_res(rmt_pkg::STS_OK, 1'b1, upd);
          end
        end else if (!pres) begin
          res_next = make_res(rmt_pkg::STS_NO_LOCK, 1'b0, rd_entry);
        end else begin
          case (req_q.operation)
            rmt_pkg::OP_ACQUIRE: begin
              if (rd_entry.held &&
                  !(rd_entry.recursive && rd_entry.owner == req_q.thread_id)) begin
                res_next = make_res(rmt_pkg::STS_BUSY, 1'b1, rd_entry);
              end else if (rd_entry.count >= rmt_pkg::COUNT_W'(rmt_pkg::MAX_COUNT)) begin
                res_next = make_res(rmt_pkg::STS_OVERFLOW, 1'b1, rd_entry);
              end else begin
                upd.count = rd_entry.count + 1'b1;
                upd.held  = 1'b1;
                upd.owner = req_q.thread_id;
                wr_en     = 1'b1;
                wr_data   = upd;
                res_next  = make_res(rmt_pkg::STS_OK, 1'b1, upd);
              end
            end
            rmt_pkg::OP_RELEASE: begin
              upd.count = dec_count;
              if (!rd_entry.recursive || dec_count == '0) begin
                upd.held  = 1'b0;
                upd.owner = '0;
              end
              wr_en    = 1'b1;
              wr_data  = upd;
              res_next = make_res(rmt_pkg::STS_OK, 1'b1, upd);
            end
            rmt_pkg::OP_REMOVE: begin
              clr_pres = 1'b1;
              res_next = make_res(rmt_pkg::STS_OK, 1'b0, rd_entry);
            end
            default: begin
              res_next = make_res(rmt_pkg::STS_OK, 1'b1, rd_entry);
            end
          endcase
        end
      end
      rmt_pkg::S_WALK: begin
        rd_addr = walk_idx + 1'b1;
        wr_addr = walk_idx;
        upd.held  = 1'b0;
        upd.owner = '0;
        upd.count = '0;
        wr_data   = upd;
        wr_en     = present[walk_idx] && rd_entry.held &&
                    (rd_entry.owner == req_q.thread_id);
        done_next = walk_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rmt_pkg::S_IDLE;
      present <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (set_pres) begin
        present[req_q.mutex_index] <= 1'b1;
      end
      if (clr_pres) begin
        present[req_q.mutex_index] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= request;
      walk_idx <= '0;
    end else if (state == rmt_pkg::S_WALK) begin
      walk_idx <= walk_idx + 1'b1;
    end
    if (done_next) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

### tb/recursive_mutex_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for recursive_mutex_table_unit: directed table, overflow run, random ops.
// Depends on rmt_pkg; expected results come from a shadow lock table predictor or pinned rows.

module recursive_mutex_table_unit_tb;
  import rmt_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 1060;
  localparam int QUIET_FIRST  = 400;
  localparam int QUIET_LAST   = 700;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    req_t rq;
    logic pinned;
    res_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  logic pin_valid;
  res_t pin_want;

  logic   lock_present [NUM_SLOTS] = '{default: 1'b0};
  entry_t lock_entry [NUM_SLOTS] = '{default: '0};
  res_t   awaited_results [$];
  int     fail_count = 0;
  int     stall_cycles = 0;

  recursive_mutex_table_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic res_t report_slot(logic [2:0] st, entry_t e);
    res_t o;
    o = '0;
    o.status       = st;
    o.is_present   = 1'b1;
    o.is_held      = e.held;
    o.owner_thread = e.held ? e.owner : '0;
    o.hold_count   = e.count;
    return o;
  endfunction

  // Applies one request to the shadow lock table and returns the result it should produce.
  function automatic res_t mutex_outcome(req_t r);
    res_t o;
    entry_t e;
    logic [SLOT_W-1:0] ix;
    o  = '0;
    ix = r.mutex_index;
    if (r.operation == OP_FREE_ALL) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (lock_present[i] && lock_entry[i].held && lock_entry[i].owner == r.thread_id) begin
          lock_entry[i].held  = 1'b0;
          lock_entry[i].owner = '0;
          lock_entry[i].count = '0;
        end
      end
      o.status = STS_OK;
      return o;
    end
    if (ix == '0 || int'(ix) >= NUM_SLOTS) begin
      o.status = STS_BAD_INDEX;
      return o;
    end
    e = lock_entry[ix];
    if (r.operation == OP_CREATE) begin
      if (lock_present[ix]) return report_slot(STS_EXISTS, e);
      lock_present[ix] = 1'b1;
      e = '0;
      e.recursive = r.recursive_flag;
      lock_entry[ix] = e;
      return report_slot(STS_OK, e);
    end
    if (!lock_present[ix]) begin
      o.status = STS_NO_LOCK;
      return o;
    end
    case (r.operation)
      OP_ACQUIRE: begin
        if (e.held && !(e.recursive && e.owner == r.thread_id)) return report_slot(STS_BUSY, e);
        if (int'(e.count) >= MAX_COUNT) return report_slot(STS_OVERFLOW, e);
        e.count = e.count + 1'b1;
        e.held  = 1'b1;
        e.owner = r.thread_id;
        lock_entry[ix] = e;
        return report_slot(STS_OK, e);
      end
      OP_RELEASE: begin
        if (e.count != '0) e.count = e.count - 1'b1;
        if (!e.recursive || e.count == '0) begin
          e.held  = 1'b0;
          e.owner = '0;
        end
        lock_entry[ix] = e;
        return report_slot(STS_OK, e);
      end
      OP_REMOVE: begin
        lock_present[ix] = 1'b0;
        o.status = STS_OK;
        return o;
      end
      default: return report_slot(STS_OK, e);
    endcase
  endfunction

  task automatic check_result(res_t got);
    res_t want;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: st=%0d pres=%0b held=%0b own=%0d cnt=%0d",
                 got.status, got.is_present, got.is_held, got.owner_thread, got.hold_count);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status || got.is_present !== want.is_present ||
        got.is_held !== want.is_held || got.owner_thread !== want.owner_thread ||
        got.hold_count !== want.hold_count) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: exp st=%0d pres=%0b held=%0b own=%0d cnt=%0d,",
                 want.status, want.is_present, want.is_held, want.owner_thread,
                 want.hold_count,
                 " got st=%0d pres=%0b held=%0b own=%0d cnt=%0d",
                 got.status, got.is_present, got.is_held, got.owner_thread, got.hold_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        res_t predicted;
        predicted = mutex_outcome(request);
        awaited_results.push_back(pin_valid ? pin_want : predicted);
      end
      if (done) check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("recursive_mutex_table_unit_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic req_t mk(logic [2:0] op, int idx, int tid, logic rec);
    req_t r;
    r.operation      = op;
    r.mutex_index    = idx[SLOT_W-1:0];
    r.thread_id      = tid[THREAD_W-1:0];
    r.recursive_flag = rec;
    return r;
  endfunction

  function automatic res_t rs(logic [2:0] st, logic pres, logic held, int own, int cnt);
    res_t o;
    o.status       = st;
    o.is_present   = pres;
    o.is_held      = held;
    o.owner_thread = own[THREAD_W-1:0];
    o.hold_count   = cnt[COUNT_W-1:0];
    return o;
  endfunction

  // Mostly a few hot slots and threads so locks collide; some noise and bad indexes.
  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    if      (pick < 15) r.operation = OP_CREATE;
    else if (pick < 45) r.operation = OP_ACQUIRE;
    else if (pick < 68) r.operation = OP_RELEASE;
    else if (pick < 76) r.operation = OP_REMOVE;
    else if (pick < 81) r.operation = OP_FREE_ALL;
    else if (pick < 95) r.operation = OP_QUERY;
    else if (pick < 98) r.operation = OP_SPARE6;
    else                r.operation = OP_SPARE7;
    pick = $urandom_range(99);
    if      (pick < 75) r.mutex_index = SLOT_W'($urandom_range(1, 8));
    else if (pick < 95) r.mutex_index = SLOT_W'($urandom_range(1, NUM_SLOTS - 1));
    else                r.mutex_index = '0;
    if ($urandom_range(99) < 70) r.thread_id = THREAD_W'($urandom_range(0, 3));
    else                         r.thread_id = THREAD_W'($urandom_range(0, NUM_THREADS - 1));
    r.recursive_flag = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic send_request(req_t r, logic pinned, res_t want);
    start     <= 1'b1;
    request   <= r;
    pin_valid <= pinned;
    pin_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  initial begin
    stim_row_t plan [$];
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    pin_valid    = 1'b0;
    pin_want     = '0;

    plan.push_back('{mk(OP_QUERY, 5, 0, 0),       1'b1, rs(STS_NO_LOCK, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_ACQUIRE, 0, 9, 0),     1'b1, rs(STS_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_CREATE, 0, 0, 1),      1'b1, rs(STS_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_CREATE, 63, 0, 1),     1'b1, rs(STS_OK, 1, 0, 0, 0)});
    plan.push_back('{mk(OP_CREATE, 63, 0, 0),     1'b1, rs(STS_EXISTS, 1, 0, 0, 0)});
    plan.push_back('{mk(OP_ACQUIRE, 63, 15, 0),   1'b0, '0});
    plan.push_back('{mk(OP_ACQUIRE, 63, 15, 1),   1'b0, '0});
    plan.push_back('{mk(OP_ACQUIRE, 63, 0, 0),    1'b0, '0});
    plan.push_back('{mk(OP_RELEASE, 63, 3, 0),    1'b0, '0});
    plan.push_back('{mk(OP_CREATE, 1, 0, 0),      1'b1, rs(STS_OK, 1, 0, 0, 0)});
    plan.push_back('{mk(OP_ACQUIRE, 1, 0, 0),     1'b0, '0});
    plan.push_back('{mk(OP_ACQUIRE, 1, 0, 0),     1'b0, '0});
    plan.push_back('{mk(OP_RELEASE, 1, 5, 0),     1'b0, '0});
    plan.push_back('{mk(OP_RELEASE, 1, 0, 0),     1'b0, '0});
    plan.push_back('{mk(OP_ACQUIRE, 1, 15, 0),    1'b0, '0});
    plan.push_back('{mk(OP_ACQUIRE, 63, 15, 0),   1'b0, '0});
    plan.push_back('{mk(OP_FREE_ALL, 0, 15, 0),   1'b1, rs(STS_OK, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_QUERY, 63, 0, 0),      1'b0, '0});
    plan.push_back('{mk(OP_SPARE6, 1, 0, 0),      1'b0, '0});
    plan.push_back('{mk(OP_SPARE7, 63, 0, 1),     1'b0, '0});
    plan.push_back('{mk(OP_REMOVE, 63, 0, 0),     1'b1, rs(STS_OK, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_REMOVE, 63, 0, 0),     1'b1, rs(STS_NO_LOCK, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_RELEASE, 63, 15, 1),   1'b1, rs(STS_NO_LOCK, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_QUERY, 0, 15, 1),      1'b1, rs(STS_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{mk(OP_FREE_ALL, 63, 0, 1),   1'b1, rs(STS_OK, 0, 0, 0, 0)});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      maybe_idle(1'b0);
      send_request(plan[i].rq, plan[i].pinned, plan[i].want);
    end

    // drive one recursive lock to its count limit and one step past it
    send_request(mk(OP_CREATE, 2, 7, 1), 1'b1, rs(STS_OK, 1, 0, 0, 0));
    for (int i = 0; i <= MAX_COUNT; i++) begin
      maybe_idle(1'b0);
      send_request(mk(OP_ACQUIRE, 2, 7, 0), 1'b0, '0);
    end
    send_request(mk(OP_RELEASE, 2, 7, 0), 1'b0, '0);
    send_request(mk(OP_FREE_ALL, 2, 7, 0), 1'b1, rs(STS_OK, 0, 0, 0, 0));
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_LAST) drain();
      maybe_idle(i >= QUIET_FIRST && i < QUIET_LAST);
      send_request(random_request(), 1'b0, '0);
    end

    drain();
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("recursive_mutex_table_unit_tb passed");
    end else begin
      $display("recursive_mutex_table_unit_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_ram.sv
hw/rtl/recursive_mutex_table_unit.sv
tb/recursive_mutex_table_unit_tb.sv
